/* design/mep_pkg.sv */
// shared types, constants and fixed-point helpers for the mandelbrot escape pixel unit
`default_nettype none

package mep_pkg;

   localparam int TILE_DIM  = 512;
   localparam int IDX_W     = 9;
   localparam int CNT_W     = 9;
   localparam int GRAY_W    = 8;
   localparam int ZOOM_W    = 6;
   localparam int Q_W       = 64;
   localparam int FRAC_W    = 60;
   localparam int SUM_W     = Q_W + 2;
   localparam int LIMB_W    = 31;
   localparam int MAG_W     = 2 * LIMB_W;
   localparam int ACC_W     = 2 * MAG_W;
   localparam int NUM_PROD  = 3;
   localparam int NUM_PAIR  = 4;
   localparam int PHASE_W   = $clog2(NUM_PROD * NUM_PAIR + 1);
   localparam int CSR_IDX_W = 2;
   localparam int LOG_TILE  = $clog2(TILE_DIM);
   localparam int D_W       = ((IDX_W > LOG_TILE) ? IDX_W : LOG_TILE) + 2;
   localparam int SH_W      = D_W + Q_W;

   localparam logic [CNT_W-1:0]   MAX_ITER   = CNT_W'(400);
   localparam logic [CNT_W-1:0]   DARK_FROM  = CNT_W'(399);
   localparam logic [Q_W-1:0]     TWO_Q      = Q_W'(1) << (FRAC_W + 1);
   localparam logic [ACC_W:0]     ESC_LIMIT  = (ACC_W + 1)'(1) << (2 * FRAC_W + 2);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(NUM_PROD * NUM_PAIR);
   localparam logic [ZOOM_W-1:0]  ZOOM_FLIP  = ZOOM_W'(FRAC_W - 1);
   localparam logic [Q_W-1:0]     Q_MAX      = {1'b0, {(Q_W - 1){1'b1}}};
   localparam logic [Q_W-1:0]     Q_MIN      = {1'b1, {(Q_W - 1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_RE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_IM = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM      = CSR_IDX_W'(2);

   typedef struct packed {
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  out_row;
      logic [IDX_W-1:0]  out_col;
      logic [CNT_W-1:0]  escape_count;
      logic [GRAY_W-1:0] gray;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MAG,
      ST_MUL,
      ST_TEST,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PROD_XX,
      PROD_YY,
      PROD_XY
   } prod_type;

   typedef struct packed {
      logic     clear;
      logic     issue;
      prod_type prod;
      logic [1:0] pair;
   } mac_ctl_type;

   // saturate a widened sum to the q3.60 range
   function automatic logic [Q_W-1:0] sat_q(input logic [SUM_W-1:0] sum);
      logic fits;
      fits = (&sum[SUM_W-1:Q_W-1]) || !(|sum[SUM_W-1:Q_W-1]);
      if (fits) begin
         return sum[Q_W-1:0];
      end else if (sum[SUM_W-1]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

   function automatic logic [Q_W-1:0] sat_add(input logic [Q_W-1:0] base, input logic neg,
                                              input logic [Q_W-1:0] mag);
      logic [SUM_W-1:0] b_ext;
      logic [SUM_W-1:0] m_ext;
      b_ext = {{2{base[Q_W-1]}}, base};
      m_ext = {2'b00, mag};
      return sat_q(neg ? (b_ext - m_ext) : (b_ext + m_ext));
   endfunction

   // center + 2^-zoom * (idx - (tile-1)/2)
   function automatic logic [Q_W-1:0] coordinate(input logic [Q_W-1:0] center,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic [ZOOM_W-1:0] zoom);
      logic [D_W-1:0]    d;
      logic [D_W-1:0]    md;
      logic [SH_W-1:0]   wide;
      logic [Q_W-1:0]    mag;
      logic [ZOOM_W-1:0] s;
      d  = D_W'({idx, 1'b0}) - D_W'(TILE_DIM - 1);
      md = d[D_W-1] ? (~d + D_W'(1)) : d;
      s  = ZOOM_FLIP - zoom;
      wide = SH_W'(md) << s;
      if (zoom <= ZOOM_FLIP) begin
         mag = (|wide[SH_W-1:Q_W]) ? {Q_W{1'b1}} : wide[Q_W-1:0];
      end else begin
         mag = Q_W'(md) >> (zoom - ZOOM_FLIP);
      end
      return sat_add(center, d[D_W-1], mag);
   endfunction

endpackage

`default_nettype wire

/* design/mandelbrot_escape_pixel_unit.sv */
// mandelbrot escape-time pixel evaluator, top level
//
// req channel: one word per pixel (row, col), taken when req_valid is high and
// req_stall low. the unit holds req_stall high from the taking of a word until
// its result has been loaded into the rsp register.
// rsp channel: one word per pixel (row, col, escape_count, gray), held in an
// output register until taken (rsp_valid high, rsp_stall low). while a result
// waits there the unit already takes and works on the next pixel.
// csr channel: writes center_re, center_im and zoom; csr_ready is always high.
// write only while the unit is idle.
// datapath: one 31x31 multiplier is shared over twelve partial products per
// iteration (x*x, y*y, x*y), so an iteration runs through a magnitude step,
// the multiply/accumulate steps and a test and update step. one pixel at a time.
// reset: synchronous; clears the configuration registers and the phase counter to
// zero, empties the rsp register and returns to idle. no clearing pass.
`default_nettype none

module mandelbrot_escape_pixel_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire mep_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output mep_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mep_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mep_pkg::Q_W-1:0]           csr_wdata
);
   import mep_pkg::*;

   state_type          state_ff, state_in;
   logic [Q_W-1:0]     center_re_ff, center_re_in;
   logic [Q_W-1:0]     center_im_ff, center_im_in;
   logic [ZOOM_W-1:0]  zoom_ff, zoom_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic [Q_W-1:0]     cre_ff, cre_in;
   logic [Q_W-1:0]     cim_ff, cim_in;
   logic [Q_W-1:0]     x_ff, x_in;
   logic [Q_W-1:0]     y_ff, y_in;
   logic [MAG_W-1:0]   mx_ff, mx_in;
   logic [MAG_W-1:0]   my_ff, my_in;
   logic               big_ff, big_in;
   logic [CNT_W-1:0]   steps_ff, steps_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   mac_ctl_type        mac_ctl;
   logic [ACC_W-1:0]   acc_xx;
   logic [ACC_W-1:0]   acc_yy;
   logic [ACC_W-1:0]   acc_xy;

   logic               req_take;
   logic               rsp_free;
   logic [Q_W-1:0]     abs_x;
   logic [Q_W-1:0]     abs_y;
   logic [ACC_W:0]     mag_sq;
   logic               escape;
   logic               last_iter;
   logic [SUM_W-1:0]   nx_sum;
   logic [Q_W-1:0]     nx;
   logic [Q_W-1:0]     ny;

   mep_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .mag_x  (mx_ff),
      .mag_y  (my_ff),
      .acc_xx (acc_xx),
      .acc_yy (acc_yy),
      .acc_xy (acc_xy)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // escape test and update from the finished products
   always_comb begin
      abs_x     = x_ff[Q_W-1] ? (~x_ff + Q_W'(1)) : x_ff;
      abs_y     = y_ff[Q_W-1] ? (~y_ff + Q_W'(1)) : y_ff;
      mag_sq    = {1'b0, acc_xx} + {1'b0, acc_yy};
      escape    = big_ff || (mag_sq > ESC_LIMIT);
      last_iter = (steps_ff == (MAX_ITER - CNT_W'(1)));
      nx_sum    = {{2{cre_ff[Q_W-1]}}, cre_ff} + {2'b00, acc_xx[FRAC_W +: Q_W]}
                  - {2'b00, acc_yy[FRAC_W +: Q_W]};
      nx        = sat_q(nx_sum);
      ny        = sat_add(cim_ff, x_ff[Q_W-1] ^ y_ff[Q_W-1], acc_xy[FRAC_W-1 +: Q_W]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_SETUP;
         end
         ST_SETUP: state_in = ST_MAG;
         ST_MAG:   state_in = ST_MUL;
         ST_MUL: begin
            if (phase_ff == PHASE_LAST) state_in = ST_TEST;
         end
         ST_TEST: begin
            state_in = (escape || last_iter) ? ST_DONE : ST_MAG;
         end
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs per state
   always_comb begin
      row_in       = row_ff;
      col_in       = col_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      big_in       = big_ff;
      steps_in     = steps_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mac_ctl      = '{clear: 1'b0, issue: 1'b0, prod: PROD_XX, pair: 2'b00};
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               row_in = req_data.row;
               col_in = req_data.col;
            end
         end
         ST_SETUP: begin
            cre_in   = coordinate(center_re_ff, col_ff, zoom_ff);
            cim_in   = coordinate(center_im_ff, row_ff, zoom_ff);
            x_in     = '0;
            y_in     = '0;
            steps_in = '0;
         end
         ST_MAG: begin
            mx_in         = abs_x[MAG_W-1:0];
            my_in         = abs_y[MAG_W-1:0];
            big_in        = (abs_x > TWO_Q) || (abs_y > TWO_Q);
            phase_in      = '0;
            mac_ctl.clear = 1'b1;
         end
         ST_MUL: begin
            mac_ctl.issue = (phase_ff != PHASE_LAST);
            mac_ctl.pair  = phase_ff[1:0];
            case (phase_ff[PHASE_W-1:2])
               2'd0:    mac_ctl.prod = PROD_XX;
               2'd1:    mac_ctl.prod = PROD_YY;
               default: mac_ctl.prod = PROD_XY;
            endcase
            phase_in = phase_ff + PHASE_W'(1);
         end
         ST_TEST: begin
            if (!escape) begin
               x_in     = nx;
               y_in     = ny;
               steps_in = steps_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_row      = row_ff;
               rsp_data_in.out_col      = col_ff;
               rsp_data_in.escape_count = steps_ff;
               rsp_data_in.gray         = (steps_ff >= DARK_FROM) ? '0
                                          : GRAY_W'(steps_ff - CNT_W'(1));
            end
         end
         default: ;
      endcase
   end

   // configuration registers
   always_comb begin
      center_re_in = center_re_ff;
      center_im_in = center_im_ff;
      zoom_in      = zoom_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CENTER_RE: center_re_in = csr_wdata;
            CSR_CENTER_IM: center_im_in = csr_wdata;
            CSR_ZOOM:      zoom_in      = csr_wdata[ZOOM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         center_re_ff <= '0;
         center_im_ff <= '0;
         zoom_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         center_re_ff <= center_re_in;
         center_im_ff <= center_im_in;
         zoom_ff      <= zoom_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      cre_ff      <= cre_in;
      cim_ff      <= cim_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      big_ff      <= big_in;
      steps_ff    <= steps_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/mep_mac.sv */
// shared limb multiplier with registered partial product and three product accumulators
`default_nettype none

module mep_mac (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mep_pkg::mac_ctl_type        ctl,
   input  wire logic [mep_pkg::MAG_W-1:0]   mag_x,
   input  wire logic [mep_pkg::MAG_W-1:0]   mag_y,
   output logic      [mep_pkg::ACC_W-1:0]   acc_xx,
   output logic      [mep_pkg::ACC_W-1:0]   acc_yy,
   output logic      [mep_pkg::ACC_W-1:0]   acc_xy
);
   import mep_pkg::*;

   logic [MAG_W-1:0]  op_a;
   logic [MAG_W-1:0]  op_b;
   logic [LIMB_W-1:0] limb_a;
   logic [LIMB_W-1:0] limb_b;
   logic [MAG_W-1:0]  pp_in;
   logic [1:0]        shift_in;
   logic [MAG_W-1:0]  pp_ff;
   logic              pp_valid_ff;
   prod_type          pp_prod_ff;
   logic [1:0]        pp_shift_ff;
   logic [ACC_W-1:0]  pp_wide;
   logic [ACC_W-1:0]  acc_xx_ff, acc_xx_in;
   logic [ACC_W-1:0]  acc_yy_ff, acc_yy_in;
   logic [ACC_W-1:0]  acc_xy_ff, acc_xy_in;

   always_comb begin
      op_a     = (ctl.prod == PROD_YY) ? mag_y : mag_x;
      op_b     = (ctl.prod == PROD_XX) ? mag_x : mag_y;
      limb_a   = ctl.pair[1] ? op_a[MAG_W-1:LIMB_W] : op_a[LIMB_W-1:0];
      limb_b   = ctl.pair[0] ? op_b[MAG_W-1:LIMB_W] : op_b[LIMB_W-1:0];
      pp_in    = MAG_W'(limb_a) * MAG_W'(limb_b);
      shift_in = 2'(ctl.pair[1]) + 2'(ctl.pair[0]);
   end

   always_comb begin
      case (pp_shift_ff)
         2'd0:    pp_wide = ACC_W'(pp_ff);
         2'd1:    pp_wide = ACC_W'(pp_ff) << LIMB_W;
         default: pp_wide = ACC_W'(pp_ff) << (2 * LIMB_W);
      endcase
   end

   always_comb begin
      acc_xx_in = acc_xx_ff;
      acc_yy_in = acc_yy_ff;
      acc_xy_in = acc_xy_ff;
      if (ctl.clear) begin
         acc_xx_in = '0;
         acc_yy_in = '0;
         acc_xy_in = '0;
      end else if (pp_valid_ff) begin
         case (pp_prod_ff)
            PROD_XX: acc_xx_in = acc_xx_ff + pp_wide;
            PROD_YY: acc_yy_in = acc_yy_ff + pp_wide;
            default: acc_xy_in = acc_xy_ff + pp_wide;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff <= ctl.issue;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff       <= pp_in;
      pp_prod_ff  <= ctl.prod;
      pp_shift_ff <= shift_in;
      acc_xx_ff   <= acc_xx_in;
      acc_yy_ff   <= acc_yy_in;
      acc_xy_ff   <= acc_xy_in;
   end

   assign acc_xx = acc_xx_ff;
   assign acc_yy = acc_yy_ff;
   assign acc_xy = acc_xy_ff;

endmodule

`default_nettype wire

/* design/mep_checker.sv */
// port-level checker for the mandelbrot escape pixel unit and its bind
`default_nettype none

module mep_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire mep_pkg::rsp_type rsp_data
);
   import mep_pkg::*;

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // one pixel at a time: busy right after a word is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req taken without going busy");

   // count is nonzero and stays within the iteration limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.escape_count != '0) && (rsp_data.escape_count <= MAX_ITER))
      else $error("escape count out of range");

   // gray level follows the count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_data.escape_count >= DARK_FROM) && (rsp_data.gray == '0)) ||
         ((rsp_data.escape_count < DARK_FROM) &&
          (rsp_data.gray == GRAY_W'(rsp_data.escape_count - CNT_W'(1)))))
      else $error("gray level does not match count");

endmodule

bind mandelbrot_escape_pixel_unit mep_checker u_mep_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* dv/mandelbrot_escape_pixel_check.sv */
// checker for the escape pixel unit: predicts each pixel word and compares it on the rsp channel
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_check (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire mep_pkg::req_type              req_data,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire mep_pkg::rsp_type              rsp_data,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [mep_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mep_pkg::Q_W-1:0]       csr_wdata,
   output int                                 errors,
   output int                                 pending
);
   import mep_pkg::*;

   localparam int ITER_CAP = 400;
   localparam int DARK_AT  = 399;
   localparam logic [Q_W-1:0]         TWO_FIX   = Q_W'(2) << FRAC_W;
   localparam logic [2*Q_W-1:0]       DISC_EDGE = (2*Q_W)'(1) << (2 * FRAC_W + 2);
   localparam logic signed [Q_W+1:0]  FIX_TOP   = {3'b000, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W+1:0]  FIX_BOT   = {3'b111, {(Q_W-1){1'b0}}};

   logic [Q_W-1:0]    center_re_q;
   logic [Q_W-1:0]    center_im_q;
   logic [ZOOM_W-1:0] zoom_q;
   rsp_type           pixel_results_due [$];
   rsp_type           want;

   function automatic logic [Q_W-1:0] abs_fix(input logic [Q_W-1:0] v);
      return v[Q_W-1] ? -v : v;
   endfunction

   function automatic logic [2*Q_W-1:0] wide_mul(input logic [Q_W-1:0] a,
                                                 input logic [Q_W-1:0] b);
      return {{Q_W{1'b0}}, a} * {{Q_W{1'b0}}, b};
   endfunction

   function automatic logic [Q_W-1:0] clamp_add(input logic [Q_W-1:0] base, input logic neg,
                                                input logic [Q_W-1:0] mag);
      logic signed [Q_W+1:0] acc;
      logic signed [Q_W+1:0] step;
      acc  = $signed({{2{base[Q_W-1]}}, base});
      step = $signed({2'b00, mag});
      acc  = neg ? acc - step : acc + step;
      if (acc > FIX_TOP) begin
         return FIX_TOP[Q_W-1:0];
      end else if (acc < FIX_BOT) begin
         return FIX_BOT[Q_W-1:0];
      end
      return acc[Q_W-1:0];
   endfunction

   function automatic logic [Q_W-1:0] pixel_coord(input logic [Q_W-1:0] center,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [ZOOM_W-1:0] zm);
      int               d;
      logic [Q_W-1:0]   md;
      logic [2*Q_W-1:0] wide;
      logic [Q_W-1:0]   mag;
      d  = 2 * int'(idx) - (TILE_DIM - 1);
      md = Q_W'(d < 0 ? -d : d);
      if (int'(zm) <= FRAC_W - 1) begin
         wide = {{Q_W{1'b0}}, md} << (FRAC_W - 1 - int'(zm));
         mag  = (wide[2*Q_W-1:Q_W] != '0) ? {Q_W{1'b1}} : wide[Q_W-1:0];
      end else begin
         mag = md >> (int'(zm) - (FRAC_W - 1));
      end
      return clamp_add(center, d < 0, mag);
   endfunction

   function automatic logic outside_disc(input logic [Q_W-1:0] x, input logic [Q_W-1:0] y);
      logic [Q_W-1:0] mx;
      logic [Q_W-1:0] my;
      mx = abs_fix(x);
      my = abs_fix(y);
      if (mx > TWO_FIX || my > TWO_FIX) begin
         return 1'b1;
      end
      return (wide_mul(mx, mx) + wide_mul(my, my)) > DISC_EDGE;
   endfunction

   function automatic rsp_type mandel_pixel(input req_type px);
      logic [Q_W-1:0]   cre;
      logic [Q_W-1:0]   cim;
      logic [Q_W-1:0]   x;
      logic [Q_W-1:0]   y;
      logic [Q_W-1:0]   nx;
      logic [Q_W-1:0]   sx;
      logic [Q_W-1:0]   sy;
      logic [Q_W-1:0]   pxy;
      logic [2*Q_W-1:0] p;
      int               n;
      rsp_type          r;
      cre = pixel_coord(center_re_q, px.col, zoom_q);
      cim = pixel_coord(center_im_q, px.row, zoom_q);
      x = '0;
      y = '0;
      n = 0;
      while (n < ITER_CAP && !outside_disc(x, y)) begin
         p   = wide_mul(abs_fix(x), abs_fix(x));
         sx  = p[FRAC_W +: Q_W];
         p   = wide_mul(abs_fix(y), abs_fix(y));
         sy  = p[FRAC_W +: Q_W];
         p   = wide_mul(abs_fix(x), abs_fix(y));
         pxy = p[FRAC_W-1 +: Q_W];
         nx  = (sx >= sy) ? clamp_add(cre, 1'b0, sx - sy) : clamp_add(cre, 1'b1, sy - sx);
         y   = clamp_add(cim, x[Q_W-1] != y[Q_W-1], pxy);
         x   = nx;
         n++;
      end
      r.out_row      = px.row;
      r.out_col      = px.col;
      r.escape_count = CNT_W'(n);
      r.gray         = (n >= DARK_AT) ? '0 : GRAY_W'(n - 1);
      return r;
   endfunction

   task automatic check_field(input string what, input logic [CNT_W-1:0] exp_v,
                              input logic [CNT_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t mismatch %s at pixel (%0d,%0d): expected %0d, actual %0d",
                  $time, what, want.out_row, want.out_col, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         center_re_q <= '0;
         center_im_q <= '0;
         zoom_q      <= '0;
         pixel_results_due.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CENTER_RE: center_re_q <= csr_wdata;
               CSR_CENTER_IM: center_im_q <= csr_wdata;
               CSR_ZOOM:      zoom_q      <= csr_wdata[ZOOM_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_results_due.size() == 0) begin
               $display("%0t unexpected word for pixel (%0d,%0d), nothing pending",
                        $time, rsp_data.out_row, rsp_data.out_col);
               errors++;
            end else begin
               want = pixel_results_due.pop_front();
               check_field("out_row", want.out_row, rsp_data.out_row);
               check_field("out_col", want.out_col, rsp_data.out_col);
               check_field("escape_count", want.escape_count, rsp_data.escape_count);
               check_field("gray", CNT_W'(want.gray), CNT_W'(rsp_data.gray));
            end
         end
         if (req_valid && !req_stall) begin
            pixel_results_due.push_back(mandel_pixel(req_data));
         end
      end
      pending = pixel_results_due.size();
   end

endmodule

/* dv/mandelbrot_escape_pixel_unit_test.sv */
// testbench top for the escape pixel unit: view settings, pixel stimulus, idling and verdict
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_unit_test;
   import mep_pkg::*;

   localparam int RANDOM_PIXELS = 1150;
   localparam int QUIET_LIMIT   = 40000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int GAPLESS_TAIL  = 150;

   localparam logic [Q_W-1:0] FIX_ZERO    = '0;
   localparam logic [Q_W-1:0] FIX_TWO     = 64'h2000_0000_0000_0000;
   localparam logic [Q_W-1:0] FIX_NEG_TWO = 64'hE000_0000_0000_0000;
   localparam logic [Q_W-1:0] FIX_NEG_3_4 = 64'hF400_0000_0000_0000;
   localparam logic [Q_W-1:0] FIX_NEG_1_2 = 64'hF800_0000_0000_0000;
   localparam logic [Q_W-1:0] FIX_TENTH   = 64'h0199_9999_9999_999A;
   localparam logic [Q_W-1:0] FIX_TWENTH  = 64'h00CC_CCCC_CCCC_CCCD;
   localparam logic [Q_W-1:0] FIX_0_26    = 64'h0428_F5C2_8F5C_28F6;
   localparam logic [Q_W-1:0] FIX_0_27    = 64'h0451_EB85_1EB8_51EC;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [Q_W-1:0]       csr_wdata = '0;
   int                   errors;
   int                   pending;
   bit                   gaps_on      = 1'b1;
   int                   quiet        = 0;
   int                   pixels_sent  = 0;
   int                   words_seen   = 0;
   int                   views_loaded = 0;

   always #1 clock = ~clock;

   mandelbrot_escape_pixel_unit dut (.*);

   mandelbrot_escape_pixel_check checker_inst (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin : rsp_side
      int n;
      forever begin
         @(negedge clock);
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input logic [IDX_W-1:0] row_idx, input logic [IDX_W-1:0] col_idx);
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_data  <= {row_idx, col_idx};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      pixels_sent++;
   endtask

   task automatic load_view(input logic [Q_W-1:0] re, input logic [Q_W-1:0] im,
                            input logic [ZOOM_W-1:0] zm);
      logic [CSR_IDX_W-1:0] idx [3];
      logic [Q_W-1:0]       vals [3];
      idx[0]  = CSR_CENTER_RE;
      idx[1]  = CSR_CENTER_IM;
      idx[2]  = CSR_ZOOM;
      vals[0] = re;
      vals[1] = im;
      vals[2] = Q_W'(zm);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      views_loaded++;
   endtask

   initial begin : stimulus
      int                left;
      int                batch;
      int                kind;
      logic [Q_W-1:0]    re;
      logic [Q_W-1:0]    im;
      logic [ZOOM_W-1:0] zm;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset view, unit spacing: corners saturate
      send_pixel(0, 0);
      send_pixel(511, 511);
      send_pixel(255, 256);
      send_pixel(256, 255);
      send_pixel(0, 511);
      send_pixel(511, 0);
      // whole set, center pixels stay inside
      load_view(FIX_ZERO, FIX_ZERO, 7);
      send_pixel(255, 255);
      send_pixel(256, 256);
      send_pixel(0, 0);
      // offsets shifted out: c at -2 exactly sits on the circle
      load_view(FIX_NEG_TWO, FIX_ZERO, 63);
      send_pixel(255, 256);
      send_pixel(256, 255);
      send_pixel(0, 511);
      // c at +2 exactly, escapes on the second step
      load_view(FIX_TWO, FIX_ZERO, 60);
      send_pixel(256, 256);
      send_pixel(255, 255);
      send_pixel(511, 0);
      // extreme centers
      load_view({1'b0, {(Q_W-1){1'b1}}}, {1'b1, {(Q_W-1){1'b0}}}, 0);
      send_pixel(511, 511);
      send_pixel(0, 0);
      send_pixel(511, 0);
      load_view(FIX_NEG_3_4, FIX_TENTH, 50);
      send_pixel(0, 0);
      send_pixel(511, 511);
      send_pixel(300, 200);
      load_view(FIX_ZERO, FIX_ZERO, 59);
      send_pixel(0, 511);

      left = RANDOM_PIXELS;
      while (left > 0) begin
         kind = $urandom_range(0, 9);
         re   = {$urandom, $urandom};
         im   = {$urandom, $urandom};
         if (kind < 4) begin
            zm    = ZOOM_W'($urandom_range(0, 3));
            batch = 110;
         end else if (kind < 5) begin
            re    = FIX_NEG_1_2 + Q_W'($urandom);
            im    = Q_W'($urandom);
            zm    = ZOOM_W'($urandom_range(6, 7));
            batch = 40;
         end else if (kind < 7) begin
            // deep zoom near the set boundary, moderate counts
            case ($urandom_range(0, 3))
               0: begin re = FIX_0_26; im = FIX_ZERO; end
               1: begin re = FIX_0_27; im = FIX_ZERO; end
               2: begin re = FIX_NEG_3_4; im = FIX_TENTH; end
               default: begin re = FIX_NEG_3_4; im = FIX_TWENTH; end
            endcase
            re    = re + Q_W'($urandom);
            zm    = ZOOM_W'($urandom_range(20, 50));
            batch = 60;
         end else if (kind < 8) begin
            zm    = ZOOM_W'($urandom_range(51, 63));
            batch = 80;
         end else begin
            zm    = ZOOM_W'($urandom_range(0, 50));
            batch = 80;
         end
         if (batch > left) begin
            batch = left;
         end
         if (left - batch < GAPLESS_TAIL) begin
            gaps_on = 1'b0;
         end
         load_view(re, im, zm);
         repeat (batch) send_pixel(IDX_W'($urandom_range(0, 511)),
                                   IDX_W'($urandom_range(0, 511)));
         left -= batch;
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("%0d pixels sent over %0d views, %0d result words checked, %0d errors",
               pixels_sent, views_loaded, words_seen, errors);
      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
design/mep_pkg.sv
design/mep_mac.sv
design/mandelbrot_escape_pixel_unit.sv
design/mep_checker.sv
dv/mandelbrot_escape_pixel_check.sv
dv/mandelbrot_escape_pixel_unit_test.sv
